>>> sv/dcp_pkg.sv
// shared types and constants of the delta correlating prefetcher
package dcp_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int MAX_DEGREE = 16;
    localparam int DEG_W      = 5;
    localparam int SH_DEPTH   = MAX_DEGREE + 1;
    localparam int J_W        = HIST_AW;
    // first delta index at which the newest pair can be matched
    localparam int FIRST_MATCH = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPEND,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0]        addr;
        logic               lvalid;
        logic [HIST_AW-1:0] link;
        logic [31:0]        pc;
    } t_hist_entry;

    typedef struct packed {
        logic [31:0]        tag;
        logic [HIST_AW-1:0] ptr;
    } t_index_entry;

    localparam int HIST_W  = $bits(t_hist_entry);
    localparam int INDEX_W = $bits(t_index_entry);

endpackage

>>> sv/dcp_ram.sv
// generic simple dual port ram with registered read
module dcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/delta_correlating_prefetcher.sv
// top level of the delta correlating prefetcher
//
// A request is taken when i_start is high and o_busy is low. A hit is absorbed with no
// result. A miss goes through index lookup and history append, then takes one cycle per
// link of its instruction's chain in the history ram (at most 255 links; the walk stops
// at the first earlier copy of the newest delta pair or at the chain's end), then one
// cycle per prefetch address; the walk through the single history read port sets how long
// a miss takes. Each prefetch address is shown for one cycle with o_valid high; the
// receiver cannot stall, and o_last marks the final one. Stale links to overwritten
// history slots are recognized by slot age, so no clearing pass is needed after reset.
module delta_correlating_prefetcher
    import dcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_instruction_address,
    input  logic [31:0] i_access_address,
    input  logic        i_is_miss,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_prefetch_address,
    output logic        o_last
);

    t_state r_state, n_state;

    logic [DEG_W-1:0]   r_deg;
    logic [31:0]        r_pc, r_addr;
    logic [HIST_AW-1:0] r_head, r_hnew;
    logic [HIST_AW-1:0] r_iptr;
    logic               r_ivld;
    logic [HIST_AW-1:0] r_link;
    logic [31:0]        r_cur_addr;
    logic [J_W-1:0]     r_j;
    logic [31:0]        r_d0, r_d1;
    logic [31:0]        r_sh [SH_DEPTH];
    logic [31:0]        r_paddr;
    logic [DEG_W-1:0]   r_cnt;
    logic [HIST_DEPTH-1:0] r_idx_valid;
    logic               r_out_valid, r_out_last;
    logic [31:0]        r_out_addr;

    logic               accept;
    logic [HIST_AW-1:0] slot;
    logic               idx_we, idx_re, hist_we, hist_re;
    logic [HIST_AW-1:0] idx_raddr, hist_raddr;
    logic [INDEX_W-1:0] idx_rdata;
    logic [HIST_W-1:0]  hist_rdata;
    t_index_entry       idx_rd, idx_wr;
    t_hist_entry        hist_rd, hist_wr;
    logic               prev_ok;
    logic [31:0]        delta;
    logic               link_ok, match;
    logic [DEG_W-1:0]   deg_sat, match_cnt;
    logic [J_W-1:0]     j_m1;

    assign accept  = i_start && !o_busy;
    assign slot    = r_pc[HIST_AW-1:0];
    assign idx_rd  = t_index_entry'(idx_rdata);
    assign hist_rd = t_hist_entry'(hist_rdata);

    // previous miss of this instruction still alive in the history
    assign prev_ok = r_ivld && (hist_rd.pc == r_pc) && (r_iptr != r_head);

    // walk step: delta, older link check by age, newest pair match
    assign delta   = r_cur_addr - hist_rd.addr;
    assign link_ok = hist_rd.lvalid &&
                     ((r_hnew - hist_rd.link) > (r_hnew - r_link));
    assign match   = (r_j >= J_W'(FIRST_MATCH)) && (delta == r_d1) && (r_sh[0] == r_d0);
    assign deg_sat = (r_deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_deg;
    assign j_m1    = r_j - 1'b1;
    assign match_cnt = ({{(J_W-DEG_W){1'b0}}, deg_sat} < j_m1) ? deg_sat : j_m1[DEG_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_is_miss) n_state = S_LOOKUP;
            end
            S_LOOKUP: n_state = S_APPEND;
            S_APPEND: n_state = prev_ok ? S_WALK : S_IDLE;
            S_WALK: begin
                if (match) n_state = (match_cnt != '0) ? S_EMIT : S_IDLE;
                else if (!link_ok) n_state = S_IDLE;
            end
            S_EMIT: begin
                if (r_cnt == DEG_W'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and memory ports
    always_comb begin
        o_busy     = 1'b1;
        idx_re     = 1'b0;
        idx_raddr  = i_instruction_address[HIST_AW-1:0];
        idx_we     = 1'b0;
        hist_re    = 1'b0;
        hist_raddr = r_iptr;
        hist_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                idx_re = accept && i_is_miss;
            end
            S_LOOKUP: begin
                hist_re    = 1'b1;
                hist_raddr = idx_rd.ptr;
            end
            S_APPEND: begin
                idx_we     = 1'b1;
                hist_we    = 1'b1;
                hist_re    = prev_ok;
                hist_raddr = r_iptr;
            end
            S_WALK: begin
                hist_re    = !match && link_ok;
                hist_raddr = hist_rd.link;
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    assign idx_wr  = '{tag: r_pc, ptr: r_head};
    assign hist_wr = '{addr: r_addr, lvalid: prev_ok, link: r_iptr, pc: r_pc};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deg       <= DEG_W'(2);
            r_head      <= '0;
            r_idx_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_EMIT);
            if (i_cfg_we) r_deg <= i_cfg_wdata;
            if (r_state == S_APPEND) begin
                r_head            <= r_head + 1'b1;
                r_idx_valid[slot] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_pc   <= i_instruction_address;
                    r_addr <= i_access_address;
                end
            end
            S_LOOKUP: begin
                r_iptr <= idx_rd.ptr;
                r_ivld <= r_idx_valid[slot] && (idx_rd.tag == r_pc);
            end
            S_APPEND: begin
                r_hnew     <= r_head;
                r_link     <= r_iptr;
                r_cur_addr <= r_addr;
                r_j        <= '0;
            end
            S_WALK: begin
                r_cur_addr <= hist_rd.addr;
                r_link     <= hist_rd.link;
                r_j        <= r_j + 1'b1;
                if (r_j == J_W'(0)) r_d0 <= delta;
                if (r_j == J_W'(1)) r_d1 <= delta;
                if (match) begin
                    r_paddr <= r_addr;
                    r_cnt   <= match_cnt;
                end else begin
                    r_sh[0] <= delta;
                    for (int i = 1; i < SH_DEPTH; i++) r_sh[i] <= r_sh[i-1];
                end
            end
            S_EMIT: begin
                r_paddr    <= r_paddr + r_sh[1];
                r_out_addr <= r_paddr + r_sh[1];
                r_out_last <= (r_cnt == DEG_W'(1));
                r_cnt      <= r_cnt - 1'b1;
                for (int i = 1; i < SH_DEPTH - 1; i++) r_sh[i] <= r_sh[i+1];
            end
            default: ;
        endcase
    end

    // index table: tag and newest slot per instruction
    dcp_ram #(.WIDTH(INDEX_W), .DEPTH(HIST_DEPTH)) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (slot),
        .i_wdata (INDEX_W'(idx_wr)),
        .i_re    (idx_re),
        .i_raddr (idx_raddr),
        .o_rdata (idx_rdata)
    );

    // history buffer: miss address, link to older miss, instruction
    dcp_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_head),
        .i_wdata (HIST_W'(hist_wr)),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    assign o_valid            = r_out_valid;
    assign o_prefetch_address = r_out_addr;
    assign o_last             = r_out_last;

endmodule
